/* design/rarc_pkg.sv */
// Package with the shared constants, command codes and control types of the rational unit.
`timescale 1ns / 1ps
package rarc_pkg;

  localparam int OperandWidth = 32;
  localparam int WideWidth    = 2 * OperandWidth;
  localparam int DenWidth     = WideWidth - 1;
  localparam int CntWidth     = $clog2(WideWidth + 1);

  typedef enum logic [3:0] {
    OP_NONE,
    OP_LOAD,
    OP_SETB,
    OP_SETD,
    OP_MUL,
    OP_SUM,
    OP_FIN,
    DV_MOD,
    DV_AN,
    DV_AD,
    DV_BN,
    DV_BD,
    DV_LQ,
    DV_LF,
    DV_SN,
    DV_SD
  } op_e;

  typedef struct packed {
    op_e op;
  } cmd_t;

  typedef struct packed {
    logic y_zero;
    logic div_done;
    logic ovf;
    logic out_free;
  } sts_t;

endpackage

/* design/rarc_if.sv */
// Request and result channel interfaces of the rational unit.
`timescale 1ns / 1ps
interface rarc_in_if;
  logic                              valid;
  logic                              ready;
  logic signed [rarc_pkg::OperandWidth-1:0] num_a;
  logic signed [rarc_pkg::OperandWidth-1:0] den_a;
  logic signed [rarc_pkg::OperandWidth-1:0] num_b;
  logic signed [rarc_pkg::OperandWidth-1:0] den_b;

  modport source (output valid, num_a, den_a, num_b, den_b, input ready);
  modport sink (input valid, num_a, den_a, num_b, den_b, output ready);
endinterface

interface rarc_out_if;
  logic                                  valid;
  logic                                  ready;
  logic signed [rarc_pkg::WideWidth-1:0] sum_num;
  logic        [rarc_pkg::DenWidth-1:0]  sum_den;
  logic                                  a_less_b;
  logic                                  a_equal_b;
  logic                                  overflow;

  modport source (output valid, sum_num, sum_den, a_less_b, a_equal_b, overflow, input ready);
  modport sink (input valid, sum_num, sum_den, a_less_b, a_equal_b, overflow, output ready);
endinterface

/* design/rarc_div.sv */
// Unsigned restoring divider that produces one quotient bit per cycle.
`timescale 1ns / 1ps
module rarc_div (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            start_i,
  input  logic [rarc_pkg::WideWidth-1:0]  dividend_i,
  input  logic [rarc_pkg::WideWidth-1:0]  divisor_i,
  output logic                            busy_o,
  output logic                            done_o,
  output logic [rarc_pkg::WideWidth-1:0]  quo_o,
  output logic [rarc_pkg::WideWidth-1:0]  rem_o
);

  logic [rarc_pkg::WideWidth-1:0] quo_q, rem_q, dvs_q;
  logic [rarc_pkg::CntWidth-1:0]  cnt_q;
  logic                           busy_q, done_q;
  logic [rarc_pkg::WideWidth:0]   shifted, diff;

  assign shifted = {rem_q, quo_q[rarc_pkg::WideWidth-1]};
  assign diff    = shifted - {1'b0, dvs_q};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      done_q <= 1'b0;
      if (start_i) begin
        busy_q <= 1'b1;
        cnt_q  <= rarc_pkg::CntWidth'(rarc_pkg::WideWidth);
      end else if (busy_q) begin
        cnt_q <= cnt_q - 1'b1;
        if (cnt_q == rarc_pkg::CntWidth'(1)) begin
          busy_q <= 1'b0;
          done_q <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      quo_q <= dividend_i;
      rem_q <= '0;
      dvs_q <= divisor_i;
    end else if (busy_q) begin
      if (!diff[rarc_pkg::WideWidth]) begin
        rem_q <= diff[rarc_pkg::WideWidth-1:0];
        quo_q <= {quo_q[rarc_pkg::WideWidth-2:0], 1'b1};
      end else begin
        rem_q <= shifted[rarc_pkg::WideWidth-1:0];
        quo_q <= {quo_q[rarc_pkg::WideWidth-2:0], 1'b0};
      end
    end
  end

  assign busy_o = busy_q;
  assign done_o = done_q;
  assign quo_o  = quo_q;
  assign rem_o  = rem_q;

endmodule

/* design/rarc_dp.sv */
// Datapath of the rational unit: operand registers, divider, multipliers and result register.
`timescale 1ns / 1ps
module rarc_dp (
  input  logic                                     clk_i,
  input  logic                                     rst_ni,
  input  rarc_pkg::cmd_t                           cmd_i,
  output rarc_pkg::sts_t                           sts_o,
  input  logic signed [rarc_pkg::OperandWidth-1:0] num_a_i,
  input  logic signed [rarc_pkg::OperandWidth-1:0] den_a_i,
  input  logic signed [rarc_pkg::OperandWidth-1:0] num_b_i,
  input  logic signed [rarc_pkg::OperandWidth-1:0] den_b_i,
  input  logic                                     out_ready_i,
  output logic                                     out_valid_o,
  output logic signed [rarc_pkg::WideWidth-1:0]    sum_num_o,
  output logic        [rarc_pkg::DenWidth-1:0]     sum_den_o,
  output logic                                     a_less_b_o,
  output logic                                     a_equal_b_o,
  output logic                                     overflow_o
);

  localparam int W  = rarc_pkg::OperandWidth;
  localparam int WW = rarc_pkg::WideWidth;

  logic [W-1:0]  an_q, ad_q, bn_q, bd_q, fa_q, fb_q;
  logic          asx_q, bsx_q, sneg_q, ovf_q, dvalid_q;
  logic [WW-1:0] x_q, y_q, lcm_q, ta_q, tb_q, pa_q, pb_q, mag_q, rn_q, rd_q;
  rarc_pkg::op_e dop_q;

  logic signed [WW-1:0] res_num_q;
  logic [WW-1:0]        res_den_q;
  logic                 less_q, equal_q, rovf_q, out_valid_q;

  logic          div_start, div_busy, div_done;
  logic [WW-1:0] div_num, div_dvs, div_quo, div_rem;

  logic [W-1:0]  abs_na, abs_da, abs_nb, abs_db;
  logic          a_neg, b_neg;
  logic [WW-1:0] sum_mag;
  logic          sum_neg;
  logic signed [WW-1:0] sa, sb;

  always_comb begin
    abs_na = num_a_i[W-1] ? W'(-num_a_i) : W'(num_a_i);
    abs_nb = num_b_i[W-1] ? W'(-num_b_i) : W'(num_b_i);
    if (den_a_i == '0) begin
      abs_da = W'(1);
    end else begin
      abs_da = den_a_i[W-1] ? W'(-den_a_i) : W'(den_a_i);
    end
    if (den_b_i == '0) begin
      abs_db = W'(1);
    end else begin
      abs_db = den_b_i[W-1] ? W'(-den_b_i) : W'(den_b_i);
    end
  end

  assign a_neg = asx_q && (an_q != '0);
  assign b_neg = bsx_q && (bn_q != '0);

  always_comb begin
    if (a_neg == b_neg) begin
      sum_mag = ta_q + tb_q;
      sum_neg = a_neg;
    end else if (ta_q >= tb_q) begin
      sum_mag = ta_q - tb_q;
      sum_neg = a_neg;
    end else begin
      sum_mag = tb_q - ta_q;
      sum_neg = b_neg;
    end
    if (sum_mag == '0) begin
      sum_neg = 1'b0;
    end
  end

  assign sa = a_neg ? -$signed(pa_q) : $signed(pa_q);
  assign sb = b_neg ? -$signed(pb_q) : $signed(pb_q);

  always_comb begin
    div_start = 1'b1;
    div_num   = x_q;
    div_dvs   = y_q;
    case (cmd_i.op)
      rarc_pkg::DV_MOD: begin
        div_num = x_q;
        div_dvs = y_q;
      end
      rarc_pkg::DV_AN: div_num = WW'(an_q);
      rarc_pkg::DV_AD: div_num = WW'(ad_q);
      rarc_pkg::DV_BN: div_num = WW'(bn_q);
      rarc_pkg::DV_BD: div_num = WW'(bd_q);
      rarc_pkg::DV_LQ: div_num = WW'(ad_q);
      rarc_pkg::DV_LF: div_num = WW'(bd_q);
      rarc_pkg::DV_SN: div_num = mag_q;
      rarc_pkg::DV_SD: div_num = lcm_q;
      default: div_start = 1'b0;
    endcase
    if (cmd_i.op != rarc_pkg::DV_MOD) begin
      div_dvs = x_q;
    end
  end

  rarc_div u_div (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (div_start),
    .dividend_i (div_num),
    .divisor_i  (div_dvs),
    .busy_o     (div_busy),
    .done_o     (div_done),
    .quo_o      (div_quo),
    .rem_o      (div_rem)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
      dvalid_q    <= 1'b0;
      dop_q       <= rarc_pkg::OP_NONE;
    end else begin
      if (div_start) begin
        dop_q    <= cmd_i.op;
        dvalid_q <= 1'b1;
      end else if (div_done) begin
        dvalid_q <= 1'b0;
      end
      if (cmd_i.op == rarc_pkg::OP_FIN) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    case (cmd_i.op)
      rarc_pkg::OP_LOAD: begin
        an_q  <= abs_na;
        ad_q  <= abs_da;
        bn_q  <= abs_nb;
        bd_q  <= abs_db;
        asx_q <= num_a_i[W-1] ^ den_a_i[W-1];
        bsx_q <= num_b_i[W-1] ^ den_b_i[W-1];
        x_q   <= WW'(abs_na);
        y_q   <= WW'(abs_da);
      end
      rarc_pkg::OP_SETB: begin
        x_q <= WW'(bn_q);
        y_q <= WW'(bd_q);
      end
      rarc_pkg::OP_SETD: begin
        x_q <= WW'(ad_q);
        y_q <= WW'(bd_q);
      end
      rarc_pkg::OP_MUL: begin
        ta_q  <= WW'(an_q) * WW'(fa_q);
        tb_q  <= WW'(bn_q) * WW'(fb_q);
        lcm_q <= WW'(fb_q) * WW'(bd_q);
        pa_q  <= WW'(an_q) * WW'(bd_q);
        pb_q  <= WW'(bn_q) * WW'(ad_q);
      end
      rarc_pkg::OP_SUM: begin
        mag_q  <= sum_mag;
        sneg_q <= sum_neg;
        ovf_q  <= !sum_neg && sum_mag[WW-1];
        x_q    <= sum_mag;
        y_q    <= lcm_q;
      end
      rarc_pkg::OP_FIN: begin
        less_q  <= sa < sb;
        equal_q <= (a_neg == b_neg) && (an_q == bn_q) && (ad_q == bd_q);
        rovf_q  <= ovf_q;
        if (ovf_q) begin
          res_num_q <= '0;
          res_den_q <= WW'(1);
        end else begin
          res_num_q <= sneg_q ? -$signed(rn_q) : $signed(rn_q);
          res_den_q <= rd_q;
        end
      end
      default: begin
      end
    endcase
    if (div_done) begin
      case (dop_q)
        rarc_pkg::DV_MOD: begin
          x_q <= y_q;
          y_q <= div_rem;
        end
        rarc_pkg::DV_AN: an_q <= div_quo[W-1:0];
        rarc_pkg::DV_AD: ad_q <= div_quo[W-1:0];
        rarc_pkg::DV_BN: bn_q <= div_quo[W-1:0];
        rarc_pkg::DV_BD: bd_q <= div_quo[W-1:0];
        rarc_pkg::DV_LQ: fb_q <= div_quo[W-1:0];
        rarc_pkg::DV_LF: fa_q <= div_quo[W-1:0];
        rarc_pkg::DV_SN: rn_q <= div_quo;
        rarc_pkg::DV_SD: rd_q <= div_quo;
        default: begin
        end
      endcase
    end
  end

  assign sts_o.y_zero   = (y_q == '0);
  assign sts_o.div_done = div_done;
  assign sts_o.ovf      = ovf_q;
  assign sts_o.out_free = !out_valid_q || out_ready_i;

  assign out_valid_o = out_valid_q;
  assign sum_num_o   = res_num_q;
  assign sum_den_o   = res_den_q[rarc_pkg::DenWidth-1:0];
  assign a_less_b_o  = less_q;
  assign a_equal_b_o = equal_q;
  assign overflow_o  = rovf_q;

`ifndef ASSERT_OFF
  // A new division must never be started while the divider is still iterating.
  a_div_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    div_start |-> !div_busy)
    else $error("division started while divider busy");

  // Every finished division belongs to a division that was started.
  a_div_owned: assert property (@(posedge clk_i) disable iff (!rst_ni)
    div_done |-> dvalid_q)
    else $error("divider finished without a pending job");

  // A reported overflow always comes with the zero-over-one result.
  a_ovf_result: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_q && rovf_q) |-> (res_num_q == '0 && res_den_q == WW'(1)))
    else $error("overflow result is not zero over one");

  // Equal operands cannot also compare as less.
  a_cmp_excl: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q |-> !(less_q && equal_q))
    else $error("less and equal flags both set");
`endif

endmodule

/* design/rarc_ctrl.sv */
// Controller state machine that sequences the Euclid loops, divisions and the final sum.
`timescale 1ns / 1ps
module rarc_ctrl (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           in_valid_i,
  output logic           in_ready_o,
  output rarc_pkg::cmd_t cmd_o,
  input  rarc_pkg::sts_t sts_i
);

  localparam logic [3:0] StIdle = 4'd0;
  localparam logic [3:0] StGcd  = 4'd1;
  localparam logic [3:0] StWait = 4'd2;
  localparam logic [3:0] StAn   = 4'd3;
  localparam logic [3:0] StAd   = 4'd4;
  localparam logic [3:0] StSetB = 4'd5;
  localparam logic [3:0] StBn   = 4'd6;
  localparam logic [3:0] StBd   = 4'd7;
  localparam logic [3:0] StSetD = 4'd8;
  localparam logic [3:0] StLq   = 4'd9;
  localparam logic [3:0] StLf   = 4'd10;
  localparam logic [3:0] StMul  = 4'd11;
  localparam logic [3:0] StSum  = 4'd12;
  localparam logic [3:0] StSn   = 4'd13;
  localparam logic [3:0] StSd   = 4'd14;
  localparam logic [3:0] StFin  = 4'd15;

  localparam logic [1:0] PhA = 2'd0;
  localparam logic [1:0] PhB = 2'd1;
  localparam logic [1:0] PhD = 2'd2;
  localparam logic [1:0] PhS = 2'd3;

  logic [3:0] state_q, state_d, ret_q, ret_d;
  logic [1:0] ph_q, ph_d;

  always_comb begin
    state_d    = state_q;
    ret_d      = ret_q;
    ph_d       = ph_q;
    cmd_o.op   = rarc_pkg::OP_NONE;
    in_ready_o = 1'b0;
    case (state_q)
      StIdle: begin
        in_ready_o = 1'b1;
        if (in_valid_i) begin
          cmd_o.op = rarc_pkg::OP_LOAD;
          ph_d     = PhA;
          state_d  = StGcd;
        end
      end
      StGcd: begin
        if (ph_q == PhS && sts_i.ovf) begin
          state_d = StFin;
        end else if (sts_i.y_zero) begin
          case (ph_q)
            PhA:     state_d = StAn;
            PhB:     state_d = StBn;
            PhD:     state_d = StLq;
            default: state_d = StSn;
          endcase
        end else begin
          cmd_o.op = rarc_pkg::DV_MOD;
          ret_d    = StGcd;
          state_d  = StWait;
        end
      end
      StWait: begin
        if (sts_i.div_done) begin
          state_d = ret_q;
        end
      end
      StAn: begin
        cmd_o.op = rarc_pkg::DV_AN;
        ret_d    = StAd;
        state_d  = StWait;
      end
      StAd: begin
        cmd_o.op = rarc_pkg::DV_AD;
        ret_d    = StSetB;
        state_d  = StWait;
      end
      StSetB: begin
        cmd_o.op = rarc_pkg::OP_SETB;
        ph_d     = PhB;
        state_d  = StGcd;
      end
      StBn: begin
        cmd_o.op = rarc_pkg::DV_BN;
        ret_d    = StBd;
        state_d  = StWait;
      end
      StBd: begin
        cmd_o.op = rarc_pkg::DV_BD;
        ret_d    = StSetD;
        state_d  = StWait;
      end
      StSetD: begin
        cmd_o.op = rarc_pkg::OP_SETD;
        ph_d     = PhD;
        state_d  = StGcd;
      end
      StLq: begin
        cmd_o.op = rarc_pkg::DV_LQ;
        ret_d    = StLf;
        state_d  = StWait;
      end
      StLf: begin
        cmd_o.op = rarc_pkg::DV_LF;
        ret_d    = StMul;
        state_d  = StWait;
      end
      StMul: begin
        cmd_o.op = rarc_pkg::OP_MUL;
        state_d  = StSum;
      end
      StSum: begin
        cmd_o.op = rarc_pkg::OP_SUM;
        ph_d     = PhS;
        state_d  = StGcd;
      end
      StSn: begin
        cmd_o.op = rarc_pkg::DV_SN;
        ret_d    = StSd;
        state_d  = StWait;
      end
      StSd: begin
        cmd_o.op = rarc_pkg::DV_SD;
        ret_d    = StFin;
        state_d  = StWait;
      end
      StFin: begin
        if (sts_i.out_free) begin
          cmd_o.op = rarc_pkg::OP_FIN;
          state_d  = StIdle;
        end
      end
      default: state_d = StIdle;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= StIdle;
      ret_q   <= StIdle;
      ph_q    <= PhA;
    end else begin
      state_q <= state_d;
      ret_q   <= ret_d;
      ph_q    <= ph_d;
    end
  end

endmodule

/* design/rational_add_reduce_compare_unit.sv */
// Top level of the rational add, reduce and compare unit.
`timescale 1ns / 1ps
// The unit takes one request of two raw fractions, normalizes each one, adds them over the
// least common multiple of the denominators, reduces the sum and flags less-than, equality and
// numerator overflow. It works on one request at a time; a request is taken while the previous
// result still waits on the output. Every Euclid step and every quotient runs on one shared
// 64-bit divider that yields one bit per cycle. A request needs up to eight quotient divisions
// plus one division per Euclid step in up to four GCD searches; when the sum overflows, the
// GCD search on the sum and the two divisions that reduce it are skipped.
module rational_add_reduce_compare_unit (
  input  logic        clk_i,
  input  logic        rst_ni,
  rarc_in_if.sink     req_i,
  rarc_out_if.source  rsp_o
);

  rarc_pkg::cmd_t cmd;
  rarc_pkg::sts_t sts;
  logic           in_ready;

  assign req_i.ready = in_ready;

  rarc_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (req_i.valid),
    .in_ready_o (in_ready),
    .cmd_o      (cmd),
    .sts_i      (sts)
  );

  rarc_dp u_dp (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cmd_i       (cmd),
    .sts_o       (sts),
    .num_a_i     (req_i.num_a),
    .den_a_i     (req_i.den_a),
    .num_b_i     (req_i.num_b),
    .den_b_i     (req_i.den_b),
    .out_ready_i (rsp_o.ready),
    .out_valid_o (rsp_o.valid),
    .sum_num_o   (rsp_o.sum_num),
    .sum_den_o   (rsp_o.sum_den),
    .a_less_b_o  (rsp_o.a_less_b),
    .a_equal_b_o (rsp_o.a_equal_b),
    .overflow_o  (rsp_o.overflow)
  );

endmodule
